### sv/cia_pkg.sv
// Shared types, constants and helper functions for the camera incidence angle block.
// Depends on nothing; every other file of the block imports it.
package cia_pkg;

    localparam int ELEV_W     = 19;
    localparam int POS_W      = 36;
    localparam int SPAN_W     = 32;
    localparam int ANGLE_W    = 16;
    localparam int CFG_W      = 36;
    localparam int CFG_IDX_W  = 3;
    localparam int GRAD_W     = 23;
    localparam int VEC_W      = 31;
    localparam int TAB_LEN    = 32;
    localparam int CIA_CORDIC_STEPS = 16;
    localparam int CW         = 35;
    localparam int ZW         = 34;

    localparam logic [29:0] DEG256_PER_RAD_Q16 = 30'd961263669;
    localparam logic [16:0] VIEW_LIMIT          = 17'd23040;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAMERA_EAST   = 3'd0,
        REG_CAMERA_NORTH  = 3'd1,
        REG_CAMERA_HEIGHT = 3'd2,
        REG_EW_SPAN       = 3'd3,
        REG_NS_SPAN       = 3'd4
    } cia_reg_t;

    typedef struct packed {
        logic [POS_W-1:0]  cam_east;
        logic [POS_W-1:0]  cam_north;
        logic [ELEV_W-1:0] cam_height;
        logic [SPAN_W-1:0] ew_span;
        logic [SPAN_W-1:0] ns_span;
    } cia_cfg_t;

    typedef struct packed {
        logic [ELEV_W-1:0] elev_nw;
        logic [ELEV_W-1:0] elev_n;
        logic [ELEV_W-1:0] elev_ne;
        logic [ELEV_W-1:0] elev_w;
        logic [ELEV_W-1:0] elev_c;
        logic [ELEV_W-1:0] elev_e;
        logic [ELEV_W-1:0] elev_sw;
        logic [ELEV_W-1:0] elev_s;
        logic [ELEV_W-1:0] elev_se;
        logic [8:0]        null_mask;
        logic [POS_W-1:0]  cell_east;
        logic [POS_W-1:0]  cell_north;
    } cia_item_t;

    // Control bits that travel with each transaction
    typedef struct packed {
        logic valid;
        logic nul;
        logic zero;
    } cia_ctl_t;

    // Signed three-component vector, each component below 2^30 in magnitude
    typedef struct packed {
        logic [VEC_W-1:0] x;
        logic [VEC_W-1:0] y;
        logic [VEC_W-1:0] z;
    } cia_vec_t;

    function automatic logic signed [GRAD_W-1:0] grad_ext(input logic [ELEV_W-1:0] v);
        return $signed({{(GRAD_W-ELEV_W){v[ELEV_W-1]}}, v});
    endfunction

    // Position of the highest set bit, zero for an empty word
    function automatic logic [6:0] msb_index64(input logic [63:0] v);
        logic [6:0] idx;
        idx = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                idx = 7'(i);
            end
        end
        return idx;
    endfunction

    // atan(2^-i) in radians, Q30
    function automatic logic [30:0] atan_q30(input int idx);
        logic [30:0] r;
        case (idx)
            0:       r = 31'd843314857;
            1:       r = 31'd497837829;
            2:       r = 31'd263043837;
            3:       r = 31'd133525159;
            4:       r = 31'd67021687;
            5:       r = 31'd33543516;
            6:       r = 31'd16775851;
            7:       r = 31'd8388437;
            8:       r = 31'd4194283;
            9:       r = 31'd2097149;
            10:      r = 31'd1048576;
            11:      r = 31'd524288;
            12:      r = 31'd262144;
            13:      r = 31'd131072;
            14:      r = 31'd65536;
            15:      r = 31'd32768;
            16:      r = 31'd16384;
            17:      r = 31'd8192;
            18:      r = 31'd4096;
            19:      r = 31'd2048;
            20:      r = 31'd1024;
            21:      r = 31'd512;
            22:      r = 31'd256;
            23:      r = 31'd128;
            24:      r = 31'd64;
            25:      r = 31'd32;
            26:      r = 31'd16;
            27:      r = 31'd8;
            28:      r = 31'd4;
            29:      r = 31'd2;
            30:      r = 31'd1;
            31:      r = 31'd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/cia_vectors.sv
// Front stages: Horn gradients, surface normal and view vector, each scaled below 2^30.
// Depends on cia_pkg.
module cia_vectors
    import cia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cia_cfg_t  cfg,
    input  logic      in_valid,
    input  cia_item_t item,
    output cia_ctl_t  ctl_out,
    output cia_vec_t  u_out,
    output cia_vec_t  w_out
);

    // Stage 1: gradients and view vector
    cia_ctl_t                  ctl1_next, ctl1_reg;
    logic signed [GRAD_W-1:0]  gx_next, gx_reg, gy_next, gy_reg;
    logic signed [POS_W:0]     wx_next, wx_reg, wy_next, wy_reg;
    logic signed [ELEV_W:0]    wz_next, wz_reg;

    always_comb
    begin
        ctl1_next = '{valid: in_valid, nul: |item.null_mask, zero: 1'b0};
        gx_next = (grad_ext(item.elev_nw) + (grad_ext(item.elev_w) <<< 1)
                   + grad_ext(item.elev_sw))
                - (grad_ext(item.elev_ne) + (grad_ext(item.elev_e) <<< 1)
                   + grad_ext(item.elev_se));
        gy_next = (grad_ext(item.elev_sw) + (grad_ext(item.elev_s) <<< 1)
                   + grad_ext(item.elev_se))
                - (grad_ext(item.elev_nw) + (grad_ext(item.elev_n) <<< 1)
                   + grad_ext(item.elev_ne));
        wx_next = $signed({cfg.cam_east[POS_W-1], cfg.cam_east})
                - $signed({item.cell_east[POS_W-1], item.cell_east});
        wy_next = $signed({cfg.cam_north[POS_W-1], cfg.cam_north})
                - $signed({item.cell_north[POS_W-1], item.cell_north});
        wz_next = $signed({cfg.cam_height[ELEV_W-1], cfg.cam_height})
                - $signed({item.elev_c[ELEV_W-1], item.elev_c});
    end

    // Stage 2: normal by span products, view vector as magnitude and sign
    cia_ctl_t          ctl2_next, ctl2_reg;
    logic [GRAD_W-1:0] gx_abs, gy_abs;
    logic [SPAN_W-1:0] h_span, v_span;
    logic [53:0]       um0_next, um0_reg, um1_next, um1_reg;
    logic [63:0]       um2_next, um2_reg;
    logic [POS_W:0]    wx_abs, wy_abs;
    logic [ELEV_W:0]   wz_abs;
    logic [2:0]        un_next, un_reg, wn_next, wn_reg;

    always_comb
    begin
        h_span = (cfg.ew_span == '0) ? SPAN_W'(1) : cfg.ew_span;
        v_span = (cfg.ns_span == '0) ? SPAN_W'(1) : cfg.ns_span;
        gx_abs = gx_reg[GRAD_W-1] ? GRAD_W'(-gx_reg) : GRAD_W'(gx_reg);
        gy_abs = gy_reg[GRAD_W-1] ? GRAD_W'(-gy_reg) : GRAD_W'(gy_reg);
        wx_abs = wx_reg[POS_W] ? (POS_W+1)'(-wx_reg) : (POS_W+1)'(wx_reg);
        wy_abs = wy_reg[POS_W] ? (POS_W+1)'(-wy_reg) : (POS_W+1)'(wy_reg);
        wz_abs = wz_reg[ELEV_W] ? (ELEV_W+1)'(-wz_reg) : (ELEV_W+1)'(wz_reg);
        um0_next = gx_abs[21:0] * v_span;
        um1_next = gy_abs[21:0] * h_span;
        um2_next = h_span * v_span;
        un_next = {1'b0, gy_reg[GRAD_W-1], gx_reg[GRAD_W-1]};
        wn_next = {wz_reg[ELEV_W], wy_reg[POS_W], wx_reg[POS_W]};
        ctl2_next = ctl1_reg;
        ctl2_next.zero = (wx_reg == '0) && (wy_reg == '0) && (wz_reg == '0);
    end

    // Stage 3: common shift counts from the leading one of each vector
    cia_ctl_t       ctl3_next, ctl3_reg;
    logic [63:0]    or_u, or_w;
    logic [6:0]     pos_u, pos_w;
    logic [6:0]     su_next, su_reg, sw_next, sw_reg;
    logic [53:0]    um0_3_reg, um1_3_reg;
    logic [63:0]    um2_3_reg;
    logic [POS_W:0] wx3_reg, wy3_reg;
    logic [ELEV_W:0] wz3_reg;
    logic [2:0]     un3_reg, wn3_reg;
    logic [POS_W:0]  wx_abs_r2, wy_abs_r2;
    logic [ELEV_W:0] wz_abs_r2;

    always_comb
    begin
        or_u = {10'b0, um0_reg} | {10'b0, um1_reg} | um2_reg;
        or_w = {27'b0, wx_abs_r2 | wy_abs_r2 | {17'b0, wz_abs_r2}};
        pos_u = msb_index64(or_u);
        pos_w = msb_index64(or_w);
        su_next = (pos_u > 7'd29) ? (pos_u - 7'd29) : 7'd0;
        sw_next = (pos_w > 7'd29) ? (pos_w - 7'd29) : 7'd0;
        ctl3_next = ctl2_reg;
    end

    // Stage 4: shift and restore signs
    cia_ctl_t    ctl4_next, ctl4_reg;
    cia_vec_t    u_next, u_reg, w_next, w_reg;
    logic [53:0] tu0, tu1;
    logic [63:0] tu2;
    logic [POS_W:0]  tw0, tw1;
    logic [ELEV_W:0] tw2;

    always_comb
    begin
        tu0 = um0_3_reg >> su_reg;
        tu1 = um1_3_reg >> su_reg;
        tu2 = um2_3_reg >> su_reg;
        tw0 = wx3_reg >> sw_reg;
        tw1 = wy3_reg >> sw_reg;
        tw2 = wz3_reg >> sw_reg;
        u_next.x = un3_reg[0] ? VEC_W'(-{1'b0, tu0[29:0]}) : {1'b0, tu0[29:0]};
        u_next.y = un3_reg[1] ? VEC_W'(-{1'b0, tu1[29:0]}) : {1'b0, tu1[29:0]};
        u_next.z = un3_reg[2] ? VEC_W'(-{1'b0, tu2[29:0]}) : {1'b0, tu2[29:0]};
        w_next.x = wn3_reg[0] ? VEC_W'(-{1'b0, tw0[29:0]}) : {1'b0, tw0[29:0]};
        w_next.y = wn3_reg[1] ? VEC_W'(-{1'b0, tw1[29:0]}) : {1'b0, tw1[29:0]};
        w_next.z = wn3_reg[2] ? VEC_W'(-{11'b0, tw2[19:0]}) : {11'b0, tw2[19:0]};
        ctl4_next = ctl3_reg;
    end

    // Advance control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl2_next;
            ctl3_reg <= ctl3_next;
            ctl4_reg <= ctl4_next;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        gx_reg    <= gx_next;
        gy_reg    <= gy_next;
        wx_reg    <= wx_next;
        wy_reg    <= wy_next;
        wz_reg    <= wz_next;
        um0_reg   <= um0_next;
        um1_reg   <= um1_next;
        um2_reg   <= um2_next;
        wx_abs_r2 <= wx_abs;
        wy_abs_r2 <= wy_abs;
        wz_abs_r2 <= wz_abs;
        un_reg    <= un_next;
        wn_reg    <= wn_next;
        su_reg    <= su_next;
        sw_reg    <= sw_next;
        um0_3_reg <= um0_reg;
        um1_3_reg <= um1_reg;
        um2_3_reg <= um2_reg;
        wx3_reg   <= wx_abs_r2;
        wy3_reg   <= wy_abs_r2;
        wz3_reg   <= wz_abs_r2;
        un3_reg   <= un_reg;
        wn3_reg   <= wn_reg;
        u_reg     <= u_next;
        w_reg     <= w_next;
    end

    assign ctl_out = ctl4_reg;
    assign u_out   = u_reg;
    assign w_out   = w_reg;

endmodule

### sv/cia_cross.sv
// Cross and dot products of the scaled vectors, rescaled below 2^31, and the sum of
// squares of the cross product. Depends on cia_pkg.
module cia_cross
    import cia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cia_ctl_t    ctl_in,
    input  cia_vec_t    u_in,
    input  cia_vec_t    w_in,
    output cia_ctl_t    ctl_out,
    output logic [63:0] sq_out,
    output logic [31:0] dot_out
);

    // Stage 5: the nine products
    cia_ctl_t           ctl5_reg;
    logic signed [61:0] p_yz_next, p_zy_next, p_zx_next, p_xz_next, p_xy_next, p_yx_next;
    logic signed [61:0] p_xx_next, p_yy_next, p_zz_next;
    logic signed [61:0] p_yz_reg, p_zy_reg, p_zx_reg, p_xz_reg, p_xy_reg, p_yx_reg;
    logic signed [61:0] p_xx_reg, p_yy_reg, p_zz_reg;

    always_comb
    begin
        p_yz_next = $signed(u_in.y) * $signed(w_in.z);
        p_zy_next = $signed(u_in.z) * $signed(w_in.y);
        p_zx_next = $signed(u_in.z) * $signed(w_in.x);
        p_xz_next = $signed(u_in.x) * $signed(w_in.z);
        p_xy_next = $signed(u_in.x) * $signed(w_in.y);
        p_yx_next = $signed(u_in.y) * $signed(w_in.x);
        p_xx_next = $signed(u_in.x) * $signed(w_in.x);
        p_yy_next = $signed(u_in.y) * $signed(w_in.y);
        p_zz_next = $signed(u_in.z) * $signed(w_in.z);
    end

    // Stage 6: combine into cross and dot
    cia_ctl_t           ctl6_reg;
    logic signed [62:0] c0_next, c1_next, c2_next, c3_next;
    logic signed [62:0] c0_reg, c1_reg, c2_reg, c3_reg;

    always_comb
    begin
        c0_next = 63'(p_yz_reg) - 63'(p_zy_reg);
        c1_next = 63'(p_zx_reg) - 63'(p_xz_reg);
        c2_next = 63'(p_xy_reg) - 63'(p_yx_reg);
        c3_next = 63'(p_xx_reg) + 63'(p_yy_reg) + 63'(p_zz_reg);
    end

    // Stage 7: magnitude and sign
    cia_ctl_t    ctl7_reg;
    logic [61:0] m0_next, m1_next, m2_next, m3_next;
    logic [61:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic        n3_next, n3_reg;

    always_comb
    begin
        m0_next = c0_reg[62] ? 62'(-c0_reg) : 62'(c0_reg);
        m1_next = c1_reg[62] ? 62'(-c1_reg) : 62'(c1_reg);
        m2_next = c2_reg[62] ? 62'(-c2_reg) : 62'(c2_reg);
        m3_next = c3_reg[62] ? 62'(-c3_reg) : 62'(c3_reg);
        n3_next = c3_reg[62];
    end

    // Stage 8: common shift count
    cia_ctl_t    ctl8_reg;
    logic [63:0] or_f;
    logic [6:0]  pos_f;
    logic [6:0]  sf_next, sf_reg;
    logic [61:0] m0_8_reg, m1_8_reg, m2_8_reg, m3_8_reg;
    logic        n3_8_reg;

    always_comb
    begin
        or_f = {2'b0, m0_reg | m1_reg | m2_reg | m3_reg};
        pos_f = msb_index64(or_f);
        sf_next = (pos_f > 7'd30) ? (pos_f - 7'd30) : 7'd0;
    end

    // Stage 9: shift, restore sign of the dot product
    cia_ctl_t    ctl9_reg;
    logic [61:0] t0, t1, t2, t3;
    logic [30:0] f0_next, f1_next, f2_next, f0_reg, f1_reg, f2_reg;
    logic [31:0] f3_next, f3_reg;

    always_comb
    begin
        t0 = m0_8_reg >> sf_reg;
        t1 = m1_8_reg >> sf_reg;
        t2 = m2_8_reg >> sf_reg;
        t3 = m3_8_reg >> sf_reg;
        f0_next = t0[30:0];
        f1_next = t1[30:0];
        f2_next = t2[30:0];
        f3_next = n3_8_reg ? 32'(-{1'b0, t3[30:0]}) : {1'b0, t3[30:0]};
    end

    // Stage 10: squares
    cia_ctl_t    ctl10_reg;
    logic [61:0] q0_next, q1_next, q2_next, q0_reg, q1_reg, q2_reg;
    logic [31:0] f3_10_reg;

    always_comb
    begin
        q0_next = f0_reg * f0_reg;
        q1_next = f1_reg * f1_reg;
        q2_next = f2_reg * f2_reg;
    end

    // Stage 11: sum of squares
    cia_ctl_t    ctl11_reg;
    logic [63:0] sq_next, sq_reg;
    logic [31:0] f3_11_reg;

    always_comb
    begin
        sq_next = {2'b0, q0_reg} + {2'b0, q1_reg} + {2'b0, q2_reg};
    end

    // Advance control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl5_reg  <= '0;
            ctl6_reg  <= '0;
            ctl7_reg  <= '0;
            ctl8_reg  <= '0;
            ctl9_reg  <= '0;
            ctl10_reg <= '0;
            ctl11_reg <= '0;
        end
        else
        begin
            ctl5_reg  <= ctl_in;
            ctl6_reg  <= ctl5_reg;
            ctl7_reg  <= ctl6_reg;
            ctl8_reg  <= ctl7_reg;
            ctl9_reg  <= ctl8_reg;
            ctl10_reg <= ctl9_reg;
            ctl11_reg <= ctl10_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        p_yz_reg  <= p_yz_next;
        p_zy_reg  <= p_zy_next;
        p_zx_reg  <= p_zx_next;
        p_xz_reg  <= p_xz_next;
        p_xy_reg  <= p_xy_next;
        p_yx_reg  <= p_yx_next;
        p_xx_reg  <= p_xx_next;
        p_yy_reg  <= p_yy_next;
        p_zz_reg  <= p_zz_next;
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        c3_reg    <= c3_next;
        m0_reg    <= m0_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        m3_reg    <= m3_next;
        n3_reg    <= n3_next;
        sf_reg    <= sf_next;
        m0_8_reg  <= m0_reg;
        m1_8_reg  <= m1_reg;
        m2_8_reg  <= m2_reg;
        m3_8_reg  <= m3_reg;
        n3_8_reg  <= n3_reg;
        f0_reg    <= f0_next;
        f1_reg    <= f1_next;
        f2_reg    <= f2_next;
        f3_reg    <= f3_next;
        q0_reg    <= q0_next;
        q1_reg    <= q1_next;
        q2_reg    <= q2_next;
        f3_10_reg <= f3_reg;
        sq_reg    <= sq_next;
        f3_11_reg <= f3_10_reg;
    end

    assign ctl_out = ctl11_reg;
    assign sq_out  = sq_reg;
    assign dot_out = f3_11_reg;

endmodule

### sv/cia_isqrt.sv
// Pipelined floor integer square root of a 64-bit value, one result bit per stage.
// Depends on cia_pkg.
module cia_isqrt
    import cia_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cia_ctl_t    ctl_in,
    input  logic [63:0] sq_in,
    input  logic [31:0] dot_in,
    output cia_ctl_t    ctl_out,
    output logic [31:0] root_out,
    output logic [31:0] dot_out
);

    localparam int NBIT = 32;

    cia_ctl_t    ctl_reg  [NBIT];
    logic [63:0] rem_reg  [NBIT];
    logic [31:0] root_reg [NBIT];
    logic [31:0] dot_reg  [NBIT];

    for (genvar j = 0; j < NBIT; j++)
    begin : g_bit
        localparam int K = NBIT - 1 - j;

        cia_ctl_t    ctl_in_s;
        logic [63:0] rem_in_s;
        logic [31:0] root_in_s;
        logic [31:0] dot_in_s;
        logic [65:0] trial;
        logic        take;
        logic [63:0] rem_next;
        logic [31:0] root_next;

        if (j == 0)
        begin : g_first
            assign ctl_in_s  = ctl_in;
            assign rem_in_s  = sq_in;
            assign root_in_s = '0;
            assign dot_in_s  = dot_in;
        end
        else
        begin : g_rest
            assign ctl_in_s  = ctl_reg[j-1];
            assign rem_in_s  = rem_reg[j-1];
            assign root_in_s = root_reg[j-1];
            assign dot_in_s  = dot_reg[j-1];
        end

        // Try the next root bit against the remainder
        always_comb
        begin
            trial = ({34'b0, root_in_s} << (K + 1)) + (66'd1 << (2 * K));
            take = ({2'b0, rem_in_s} >= trial);
            rem_next = take ? (rem_in_s - trial[63:0]) : rem_in_s;
            root_next = take ? (root_in_s | (32'd1 << K)) : root_in_s;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else
            begin
                ctl_reg[j] <= ctl_in_s;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j]  <= rem_next;
            root_reg[j] <= root_next;
            dot_reg[j]  <= dot_in_s;
        end
    end

    assign ctl_out  = ctl_reg[NBIT-1];
    assign root_out = root_reg[NBIT-1];
    assign dot_out  = dot_reg[NBIT-1];

endmodule

### sv/cia_cordic.sv
// Pipelined vectoring CORDIC: angle of (x, y) in radians Q30, one iteration per stage.
// Depends on cia_pkg for the arctangent table.
module cia_cordic
    import cia_pkg::*;
#(
    parameter int CORDIC_STEPS = CIA_CORDIC_STEPS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cia_ctl_t             ctl_in,
    input  logic [31:0]          x_in,
    input  logic [31:0]          y_in,
    output cia_ctl_t             ctl_out,
    output logic signed [ZW-1:0] z_out
);

    localparam int NSTEP = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

    cia_ctl_t             ctl_reg [NSTEP];
    logic signed [CW-1:0] x_reg   [NSTEP];
    logic signed [CW-1:0] y_reg   [NSTEP];
    logic signed [ZW-1:0] z_reg   [NSTEP];

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        cia_ctl_t             ctl_s;
        logic signed [CW-1:0] x_s, y_s, xs, ys, x_next, y_next;
        logic signed [ZW-1:0] z_s, z_next, a_s;

        if (i == 0)
        begin : g_first
            assign ctl_s = ctl_in;
            assign x_s   = $signed({3'b0, x_in});
            assign y_s   = $signed({{3{y_in[31]}}, y_in});
            assign z_s   = '0;
        end
        else
        begin : g_rest
            assign ctl_s = ctl_reg[i-1];
            assign x_s   = x_reg[i-1];
            assign y_s   = y_reg[i-1];
            assign z_s   = z_reg[i-1];
        end

        // Rotate toward the x axis
        always_comb
        begin
            xs = x_s >>> i;
            ys = y_s >>> i;
            a_s = $signed({3'b0, atan_q30(i)});
            if (!y_s[CW-1])
            begin
                x_next = x_s + ys;
                y_next = y_s - xs;
                z_next = z_s + a_s;
            end
            else
            begin
                x_next = x_s - ys;
                y_next = y_s + xs;
                z_next = z_s - a_s;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else
            begin
                ctl_reg[i] <= ctl_s;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i] <= x_next;
            y_reg[i] <= y_next;
            z_reg[i] <= z_next;
        end
    end

    assign ctl_out = ctl_reg[NSTEP-1];
    assign z_out   = z_reg[NSTEP-1];

endmodule

### sv/cia_degree.sv
// Radians Q30 to 1/256 degree with rounding and clamping, plus the null and
// zero-vector overrides; holds the output registers. Depends on cia_pkg.
module cia_degree
    import cia_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cia_ctl_t                  ctl_in,
    input  logic signed [ZW-1:0]      z_in,
    output logic                      done,
    output logic signed [ANGLE_W-1:0] view_angle,
    output logic                      angle_valid
);

    // Stage A: scale the angle magnitude
    cia_ctl_t    ctla_reg;
    logic [ZW-1:0] z_abs;
    logic [61:0] prod_next, prod_reg;
    logic        neg_next, neg_reg;

    always_comb
    begin
        z_abs = z_in[ZW-1] ? ZW'(-z_in) : ZW'(z_in);
        prod_next = z_abs[31:0] * DEG256_PER_RAD_Q16;
        neg_next = z_in[ZW-1];
    end

    // Stage B: round, clamp, apply sign and overrides
    logic [61:0]               rounded;
    logic [16:0]               dmag;
    logic                      done_next, done_reg;
    logic signed [ANGLE_W-1:0] angle_next, angle_reg;
    logic                      valid_next, valid_reg;

    always_comb
    begin
        rounded = (prod_reg + (62'd1 << 45)) >> 46;
        dmag = (rounded > 62'(VIEW_LIMIT)) ? VIEW_LIMIT : rounded[16:0];
        angle_next = neg_reg ? ANGLE_W'(-$signed({1'b0, dmag[15:0]}))
                             : ANGLE_W'($signed({1'b0, dmag[15:0]}));
        valid_next = 1'b1;
        if (ctla_reg.nul)
        begin
            angle_next = '0;
            valid_next = 1'b0;
        end
        else if (ctla_reg.zero)
        begin
            angle_next = '0;
        end
        done_next = ctla_reg.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctla_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctla_reg <= ctl_in;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        angle_reg <= angle_next;
        valid_reg <= valid_next;
    end

    assign done        = done_reg;
    assign view_angle  = angle_reg;
    assign angle_valid = valid_reg;

endmodule

### sv/camera_incidence_angle_top.sv
// Camera incidence angle top level: 11 vector stages, 32 square-root stages, one stage
// per CORDIC iteration and 2 conversion stages. One transaction is accepted every cycle;
// busy stays low, and each result shows on the ports for one cycle under done.
// Reset clears the control valid bits and loads the register defaults (spans 16, positions 0).
// Depends on cia_pkg, cia_vectors, cia_cross, cia_isqrt, cia_cordic, cia_degree.
module camera_incidence_angle_top
    import cia_pkg::*;
#(
    parameter int CORDIC_STEPS = CIA_CORDIC_STEPS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic signed [ELEV_W-1:0]  elev_nw,
    input  logic signed [ELEV_W-1:0]  elev_n,
    input  logic signed [ELEV_W-1:0]  elev_ne,
    input  logic signed [ELEV_W-1:0]  elev_w,
    input  logic signed [ELEV_W-1:0]  elev_c,
    input  logic signed [ELEV_W-1:0]  elev_e,
    input  logic signed [ELEV_W-1:0]  elev_sw,
    input  logic signed [ELEV_W-1:0]  elev_s,
    input  logic signed [ELEV_W-1:0]  elev_se,
    input  logic [8:0]                null_mask,
    input  logic signed [POS_W-1:0]   cell_east,
    input  logic signed [POS_W-1:0]   cell_north,
    output logic                      done,
    output logic signed [ANGLE_W-1:0] view_angle,
    output logic                      angle_valid
);

    localparam int CORDIC_N = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
    localparam int LATENCY  = 11 + 32 + CORDIC_N + 2;

    // Configuration registers
    cia_cfg_t cfg_next, cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cia_reg_t'(cfg_index))
                REG_CAMERA_EAST:   cfg_next.cam_east   = cfg_data[POS_W-1:0];
                REG_CAMERA_NORTH:  cfg_next.cam_north  = cfg_data[POS_W-1:0];
                REG_CAMERA_HEIGHT: cfg_next.cam_height = cfg_data[ELEV_W-1:0];
                REG_EW_SPAN:       cfg_next.ew_span    = cfg_data[SPAN_W-1:0];
                REG_NS_SPAN:       cfg_next.ns_span    = cfg_data[SPAN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_east   <= '0;
            cfg_reg.cam_north  <= '0;
            cfg_reg.cam_height <= '0;
            cfg_reg.ew_span    <= SPAN_W'(16);
            cfg_reg.ns_span    <= SPAN_W'(16);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline takes a transaction every cycle
    assign busy = 1'b0;

    cia_item_t item;
    assign item = '{elev_nw: elev_nw, elev_n: elev_n, elev_ne: elev_ne, elev_w: elev_w,
                    elev_c: elev_c, elev_e: elev_e, elev_sw: elev_sw, elev_s: elev_s,
                    elev_se: elev_se, null_mask: null_mask, cell_east: cell_east,
                    cell_north: cell_north};

    cia_ctl_t             ctl_v, ctl_x, ctl_q, ctl_c;
    cia_vec_t             u_v, w_v;
    logic [63:0]          sq_x;
    logic [31:0]          dot_x, dot_q, root_q;
    logic signed [ZW-1:0] z_c;

    cia_vectors u_vectors (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (start && !busy),
        .item     (item),
        .ctl_out  (ctl_v),
        .u_out    (u_v),
        .w_out    (w_v)
    );

    cia_cross u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_v),
        .u_in    (u_v),
        .w_in    (w_v),
        .ctl_out (ctl_x),
        .sq_out  (sq_x),
        .dot_out (dot_x)
    );

    cia_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_x),
        .sq_in    (sq_x),
        .dot_in   (dot_x),
        .ctl_out  (ctl_q),
        .root_out (root_q),
        .dot_out  (dot_q)
    );

    cia_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_q),
        .x_in    (root_q),
        .y_in    (dot_q),
        .ctl_out (ctl_c),
        .z_out   (z_c)
    );

    cia_degree u_degree (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_in      (ctl_c),
        .z_in        (z_c),
        .done        (done),
        .view_angle  (view_angle),
        .angle_valid (angle_valid)
    );

    // Every accepted transaction comes out after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(LATENCY) done)
        else $error("transaction lost in pipeline");

    // No result without a transaction that entered the fixed latency earlier
    a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without transaction");

    // A null window gives a zero angle
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !angle_valid |-> view_angle == '0)
        else $error("null result carries an angle");

    // The angle stays within plus or minus 90 degrees
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (view_angle <= 16'sd23040) && (view_angle >= -16'sd23040))
        else $error("angle out of range");

endmodule

### tb/camera_incidence_angle_top_test.sv
// Self-checking testbench for camera_incidence_angle_top: directed and random windows
// checked against an in-bench Horn/CORDIC predictor. Depends on cia_pkg and the RTL.
module camera_incidence_angle_top_test;
    import cia_pkg::*;

    localparam int STEPS      = CIA_CORDIC_STEPS;
    localparam int LATENCY    = 45 + ((STEPS > 32) ? 32 : STEPS);
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEM_W     = $bits(cia_item_t);

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      valid;
    } angle_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic signed [ELEV_W-1:0]  elev_nw, elev_n, elev_ne, elev_w, elev_c;
    logic signed [ELEV_W-1:0]  elev_e, elev_sw, elev_s, elev_se;
    logic [8:0]                null_mask;
    logic signed [POS_W-1:0]   cell_east;
    logic signed [POS_W-1:0]   cell_north;
    logic                      done;
    logic signed [ANGLE_W-1:0] view_angle;
    logic                      angle_valid;

    // Shadow of the configuration registers
    logic signed [POS_W-1:0]   sh_cam_east;
    logic signed [POS_W-1:0]   sh_cam_north;
    logic signed [ELEV_W-1:0]  sh_cam_height;
    logic [SPAN_W-1:0]         sh_ew_span;
    logic [SPAN_W-1:0]         sh_ns_span;

    longint                    atan_table [TAB_LEN];
    angle_result_t             expected_angles [$];
    int                        error_count;
    int                        burst_left;
    int                        idle_cycles;

    camera_incidence_angle_top #(.CORDIC_STEPS(STEPS)) dut
    (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .elev_nw(elev_nw), .elev_n(elev_n), .elev_ne(elev_ne),
        .elev_w(elev_w), .elev_c(elev_c), .elev_e(elev_e),
        .elev_sw(elev_sw), .elev_s(elev_s), .elev_se(elev_se),
        .null_mask(null_mask), .cell_east(cell_east), .cell_north(cell_north),
        .done(done), .view_angle(view_angle), .angle_valid(angle_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build atan(2^-i) in Q30 from the alternating series in Q60; i = 0 takes pi/4 as a constant
    initial
    begin
        longint unsigned acc;
        longint unsigned nn;
        int k;
        for (int i = 0; i < TAB_LEN; i++)
        begin
            acc = 0;
            if (i == 0)
            begin
                acc = 64'h0C90FDAA22168C23;
            end
            else
            begin
                k = 0;
                for (nn = 1; nn * longint'(i) <= 60; nn += 2)
                begin
                    if (k % 2 == 1)
                        acc -= (64'd1 << (60 - nn * i)) / nn;
                    else
                        acc += (64'd1 << (60 - nn * i)) / nn;
                    k++;
                end
            end
            atan_table[i] = longint'((acc + (64'd1 << 29)) >> 30);
        end
    end

    function automatic longint unsigned mag_of(input longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // Smallest right shift that brings the largest magnitude below 2^bits
    function automatic int norm_shift(input longint unsigned mx, input int bits);
        int s;
        s = 0;
        while ((mx >> s) >= (64'd1 << bits))
            s++;
        return s;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Incidence angle of the camera on one window under the shadow registers
    function automatic angle_result_t predict_angle(input cia_item_t it);
        angle_result_t   res;
        longint          e [9];
        longint          gx, gy, wx, wy, wz, z, xs, ys, cx, cy;
        longint unsigned h, v, mx, sq, prod, dmag;
        longint unsigned um [3];
        longint unsigned wm [3];
        longint unsigned fm [4];
        bit              un [3];
        bit              wn [3];
        bit              fn [4];
        longint          u [3];
        longint          w [3];
        longint          f [4];
        longint          cr [4];
        int              s, n;
        res.angle = '0;
        res.valid = 1'b0;
        if (it.null_mask != 0)
            return res;
        e[0] = longint'($signed(it.elev_nw)); e[1] = longint'($signed(it.elev_n));
        e[2] = longint'($signed(it.elev_ne)); e[3] = longint'($signed(it.elev_w));
        e[4] = longint'($signed(it.elev_c));  e[5] = longint'($signed(it.elev_e));
        e[6] = longint'($signed(it.elev_sw)); e[7] = longint'($signed(it.elev_s));
        e[8] = longint'($signed(it.elev_se));
        gx = (e[0] + 2 * e[3] + e[6]) - (e[2] + 2 * e[5] + e[8]);
        gy = (e[6] + 2 * e[7] + e[8]) - (e[0] + 2 * e[1] + e[2]);
        h = (sh_ew_span != 0) ? longint'(sh_ew_span) : 1;
        v = (sh_ns_span != 0) ? longint'(sh_ns_span) : 1;
        um[0] = mag_of(gx) * v; un[0] = gx < 0;
        um[1] = mag_of(gy) * h; un[1] = gy < 0;
        um[2] = h * v;          un[2] = 0;
        wx = longint'(sh_cam_east) - longint'($signed(it.cell_east));
        wy = longint'(sh_cam_north) - longint'($signed(it.cell_north));
        wz = longint'(sh_cam_height) - e[4];
        res.valid = 1'b1;
        // Camera at the cell centre: no direction to measure
        if (wx == 0 && wy == 0 && wz == 0)
            return res;
        wm[0] = mag_of(wx); wn[0] = wx < 0;
        wm[1] = mag_of(wy); wn[1] = wy < 0;
        wm[2] = mag_of(wz); wn[2] = wz < 0;

        // Normalize both vectors below 2^30
        mx = 0;
        for (int i = 0; i < 3; i++)
            if (um[i] > mx) mx = um[i];
        s = norm_shift(mx, 30);
        for (int i = 0; i < 3; i++)
            u[i] = un[i] ? -longint'(um[i] >> s) : longint'(um[i] >> s);
        mx = 0;
        for (int i = 0; i < 3; i++)
            if (wm[i] > mx) mx = wm[i];
        s = norm_shift(mx, 30);
        for (int i = 0; i < 3; i++)
            w[i] = wn[i] ? -longint'(wm[i] >> s) : longint'(wm[i] >> s);

        // Cross and dot products, then normalize below 2^31
        cr[0] = u[1] * w[2] - u[2] * w[1];
        cr[1] = u[2] * w[0] - u[0] * w[2];
        cr[2] = u[0] * w[1] - u[1] * w[0];
        cr[3] = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
        mx = 0;
        for (int i = 0; i < 4; i++)
        begin
            fm[i] = mag_of(cr[i]);
            fn[i] = cr[i] < 0;
            if (fm[i] > mx) mx = fm[i];
        end
        s = norm_shift(mx, 31);
        for (int i = 0; i < 4; i++)
            f[i] = fn[i] ? -longint'(fm[i] >> s) : longint'(fm[i] >> s);
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq += mag_of(f[i]) * mag_of(f[i]);

        // Vectoring CORDIC on (|n x w|, n.w)
        cx = longint'(floor_sqrt(sq));
        cy = f[3];
        z = 0;
        n = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;
        for (int i = 0; i < n; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (cy >= 0)
            begin
                cx += ys; cy -= xs; z += atan_table[i];
            end
            else
            begin
                cx -= ys; cy += xs; z -= atan_table[i];
            end
        end

        // Radians Q30 to 1/256 degree, round half away from zero, clamp
        prod = mag_of(z) * 64'd961263669;
        dmag = (prod + (64'd1 << 45)) >> 46;
        if (dmag > 23040)
            dmag = 23040;
        res.angle = (z < 0) ? -ANGLE_W'(dmag) : ANGLE_W'(dmag);
        return res;
    endfunction

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        angle_result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_angles.size() == 0)
            begin
                $error("unexpected result: view_angle %0d angle_valid %0b",
                       view_angle, angle_valid);
                error_count++;
            end
            else
            begin
                exp_r = expected_angles.pop_front();
                if (view_angle !== exp_r.angle)
                begin
                    $error("view_angle: expected %0d actual %0d", exp_r.angle, view_angle);
                    error_count++;
                end
                if (angle_valid !== exp_r.valid)
                begin
                    $error("angle_valid: expected %0b actual %0b", exp_r.valid, angle_valid);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'({$urandom, $urandom});
    endfunction

    function automatic int rand_sym(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // Send one window and record its expected result; gap between bursts
    task automatic send_window(input cia_item_t it);
        int gap;
        start      <= 1'b1;
        elev_nw    <= it.elev_nw;  elev_n  <= it.elev_n;  elev_ne <= it.elev_ne;
        elev_w     <= it.elev_w;   elev_c  <= it.elev_c;  elev_e  <= it.elev_e;
        elev_sw    <= it.elev_sw;  elev_s  <= it.elev_s;  elev_se <= it.elev_se;
        null_mask  <= it.null_mask;
        cell_east  <= it.cell_east;
        cell_north <= it.cell_north;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        expected_angles.push_back(predict_angle(it));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stop sending and wait for every expected result plus the pipeline depth
    task automatic drain();
        start <= 1'b0;
        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Drive one register write for a cycle; the caller drops the write enable
    task automatic write_reg(input cia_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_CAMERA_EAST:   sh_cam_east   = val[POS_W-1:0];
            REG_CAMERA_NORTH:  sh_cam_north  = val[POS_W-1:0];
            REG_CAMERA_HEIGHT: sh_cam_height = val[ELEV_W-1:0];
            REG_EW_SPAN:       sh_ew_span    = val[SPAN_W-1:0];
            REG_NS_SPAN:       sh_ns_span    = val[SPAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [POS_W-1:0] ce, input logic [POS_W-1:0] cn,
                             input logic [ELEV_W-1:0] ch, input logic [SPAN_W-1:0] ew,
                             input logic [SPAN_W-1:0] ns);
        write_reg(REG_CAMERA_EAST, CFG_W'(ce));
        write_reg(REG_CAMERA_NORTH, CFG_W'(cn));
        write_reg(REG_CAMERA_HEIGHT, CFG_W'(ch));
        write_reg(REG_EW_SPAN, CFG_W'(ew));
        write_reg(REG_NS_SPAN, CFG_W'(ns));
        cfg_we <= 1'b0;
    endtask

    function automatic cia_item_t flat_window(input int el, input logic [POS_W-1:0] ce,
                                              input logic [POS_W-1:0] cn);
        cia_item_t it;
        it.elev_nw = ELEV_W'(el); it.elev_n = ELEV_W'(el); it.elev_ne = ELEV_W'(el);
        it.elev_w  = ELEV_W'(el); it.elev_c = ELEV_W'(el); it.elev_e  = ELEV_W'(el);
        it.elev_sw = ELEV_W'(el); it.elev_s = ELEV_W'(el); it.elev_se = ELEV_W'(el);
        it.null_mask  = '0;
        it.cell_east  = ce;
        it.cell_north = cn;
        return it;
    endfunction

    // Random window: mostly valid terrain near the camera, some noise and nulls
    function automatic cia_item_t random_window();
        cia_item_t it;
        int base, rough, sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
        begin
            it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom});
            it.null_mask = '0;
        end
        else
        begin
            base  = rand_sym(200000);
            rough = (sel < 60) ? 64 : 4000;
            it.elev_nw = ELEV_W'(base + rand_sym(rough));
            it.elev_n  = ELEV_W'(base + rand_sym(rough));
            it.elev_ne = ELEV_W'(base + rand_sym(rough));
            it.elev_w  = ELEV_W'(base + rand_sym(rough));
            it.elev_c  = ELEV_W'(base);
            it.elev_e  = ELEV_W'(base + rand_sym(rough));
            it.elev_sw = ELEV_W'(base + rand_sym(rough));
            it.elev_s  = ELEV_W'(base + rand_sym(rough));
            it.elev_se = ELEV_W'(base + rand_sym(rough));
            it.null_mask  = '0;
            it.cell_east  = sh_cam_east + POS_W'(rand_sym(100000));
            it.cell_north = sh_cam_north + POS_W'(rand_sym(100000));
            if (sel < 25)
                it.elev_c = sh_cam_height;
            if (sel < 23)
            begin
                it.cell_east  = sh_cam_east;
                it.cell_north = sh_cam_north;
            end
        end
        if (sel >= 85)
            it.null_mask = 9'($urandom_range(1, 511));
        return it;
    endfunction

    task automatic test_directed();
        cia_item_t it;
        // Camera at the cell centre with reset registers
        send_window(flat_window(0, '0, '0));
        // Zero height difference, flat ground
        send_window(flat_window(0, POS_W'(160), POS_W'(-320)));
        // Each cell of the window null on its own, then all of them
        for (int b = 0; b < 9; b++)
        begin
            it = flat_window(100, POS_W'(50), POS_W'(50));
            it.null_mask = 9'(1 << b);
            send_window(it);
        end
        it.null_mask = 9'h1FF;
        send_window(it);
        // Elevation extremes
        send_window(flat_window(262143, POS_W'(1), POS_W'(1)));
        send_window(flat_window(-262144, POS_W'(-1), POS_W'(1)));
        it = flat_window(262143, '0, '0);
        it.elev_ne = ELEV_W'(-262144); it.elev_e = ELEV_W'(-262144);
        it.elev_se = ELEV_W'(-262144);
        it.elev_n  = ELEV_W'(-262144); it.elev_c = '0;
        send_window(it);
        it = flat_window(-262144, POS_W'(36'h7FFFFFFFF), POS_W'(36'h800000000));
        it.elev_nw = ELEV_W'(262143); it.elev_w = ELEV_W'(262143);
        it.elev_s  = ELEV_W'(262143);
        send_window(it);
        // Camera below the cell
        send_window(flat_window(5000, POS_W'(80), POS_W'(-40)));
        drain();
        // Zero spans, extreme camera position
        write_all(36'h800000000, 36'h7FFFFFFFF, 19'h3FFFF, 32'd0, 32'd0);
        send_window(flat_window(0, POS_W'(36'h7FFFFFFFF), POS_W'(36'h800000000)));
        send_window(flat_window(-262144, '0, '0));
        drain();
        write_all(36'h7FFFFFFFF, 36'h800000000, 19'h40000, 32'hFFFFFFFF, 32'd1);
        send_window(flat_window(262143, POS_W'(36'h800000000), POS_W'(36'h7FFFFFFFF)));
        send_window(random_window());
        drain();
    endtask

    task automatic test_random_phases();
        int sel;
        for (int p = 0; p < 10; p++)
        begin
            sel = p % 5;
            case (sel)
                0: write_all(rand_pos(), rand_pos(), 19'($urandom), $urandom, $urandom);
                1: write_all(rand_pos(), rand_pos(), 19'($urandom), 32'd1, 32'hFFFFFFFF);
                2: write_all(POS_W'(rand_sym(1000000)), POS_W'(rand_sym(1000000)),
                             19'(rand_sym(262143)), 32'($urandom_range(0, 4096)),
                             32'($urandom_range(0, 4096)));
                3: write_all(POS_W'(rand_sym(5000)), POS_W'(rand_sym(5000)),
                             19'(rand_sym(262143)), 32'd16, 32'd16);
                default: write_all(rand_pos(), rand_pos(), 19'($urandom),
                                   32'($urandom_range(1, 65536)), 32'($urandom));
            endcase
            repeat (112) send_window(random_window());
            drain();
        end
    endtask

    // Hold the sender until the pipeline is empty, then resume at full rate
    task automatic test_full_drain();
        burst_left = 60;
        repeat (30) send_window(random_window());
        drain();
        repeat (20) send_window(random_window());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        elev_nw = '0; elev_n = '0; elev_ne = '0; elev_w = '0; elev_c = '0;
        elev_e = '0; elev_sw = '0; elev_s = '0; elev_se = '0;
        null_mask = '0; cell_east = '0; cell_north = '0;
        sh_cam_east = '0; sh_cam_north = '0; sh_cam_height = '0;
        sh_ew_span = 32'd16; sh_ns_span = 32'd16;
        error_count = 0;
        burst_left = 0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_full_drain();
        drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
